>>> src/plfc_pkg.sv
package plfc_pkg;

    // Field widths of the sample, the result and the registers
    localparam int TimeW   = 32;
    localparam int EchoW   = 15;
    localparam int CountW  = 4;
    localparam int MsW     = 16;
    localparam int AngleW  = 8;
    localparam int LevelW  = 2;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    // Register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] REG_DETECT_ECHO_MAX = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_REQUIRED_DETECTS = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_HOLD_MS = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_FULL_ECHO_MAX = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MEDIUM_ECHO_MAX = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_BUZZ_MS = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_ANGLE_OPEN = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_CLOSED_ANGLE = 3'd7;

    // Fill level codes
    localparam logic [LevelW-1:0] LEVEL_EMPTY = 2'd0;
    localparam logic [LevelW-1:0] LEVEL_MEDIUM = 2'd1;
    localparam logic [LevelW-1:0] LEVEL_FULL = 2'd2;

    // Register reset values
    localparam logic [EchoW-1:0]  RST_DETECT_ECHO_MAX = 15'd583;
    localparam logic [CountW-1:0] RST_REQUIRED_DETECTS = 4'd2;
    localparam logic [MsW-1:0]    RST_HOLD_MS = 16'd3000;
    localparam logic [EchoW-1:0]  RST_FULL_ECHO_MAX = 15'd291;
    localparam logic [EchoW-1:0]  RST_MEDIUM_ECHO_MAX = 15'd699;
    localparam logic [MsW-1:0]    RST_BUZZ_MS = 16'd1000;
    localparam logic [AngleW-1:0] RST_ANGLE_OPEN = 8'd100;
    localparam logic [AngleW-1:0] RST_CLOSED_ANGLE = 8'd50;

    // All configuration registers as one bundle
    typedef struct packed {
        logic [EchoW-1:0]  detect_echo_max_us;
        logic [CountW-1:0] required_detects;
        logic [MsW-1:0]    hold_ms;
        logic [EchoW-1:0]  full_echo_max_us;
        logic [EchoW-1:0]  medium_echo_max_us;
        logic [MsW-1:0]    buzz_ms;
        logic [AngleW-1:0] angle_open;
        logic [AngleW-1:0] closed_angle;
    } cfg_t;

    // Sample held in the input register
    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic [EchoW-1:0] outer_echo_us;
        logic [EchoW-1:0] inner_echo_us;
    } sample_t;

endpackage

>>> src/plfc_if.sv
// Sample channel: one sensor reading per item.
interface plfc_in_if;
    logic                        valid;
    logic                        ready;
    logic [plfc_pkg::TimeW-1:0]  now_ms;
    logic [plfc_pkg::EchoW-1:0]  outer_echo_us;
    logic [plfc_pkg::EchoW-1:0]  inner_echo_us;

    modport source (output valid, output now_ms, output outer_echo_us,
                    output inner_echo_us, input ready);
    modport sink (input valid, input now_ms, input outer_echo_us,
                  input inner_echo_us, output ready);
endinterface

// Result channel: lid, servo, fill and buzzer state per item.
interface plfc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        lid_open;
    logic [plfc_pkg::AngleW-1:0] servo_angle;
    logic [plfc_pkg::LevelW-1:0] fill_level;
    logic                        buzzer_on;

    modport source (output valid, output lid_open, output servo_angle,
                    output fill_level, output buzzer_on, input ready);
    modport sink (input valid, input lid_open, input servo_angle,
                  input fill_level, input buzzer_on, output ready);
endinterface

// Configuration write channel.
interface plfc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [plfc_pkg::CfgIdxW-1:0] index;
    logic [plfc_pkg::CfgDatW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/plfc_cfg_regs.sv
module plfc_cfg_regs
(
    input  logic             clk,
    input  logic             rst_n,
    plfc_cfg_if.sink         cfg,
    output plfc_pkg::cfg_t   regs
);

    plfc_pkg::cfg_t regs_reg;
    plfc_pkg::cfg_t regs_next;

    // Writes are always taken; the value is cut to the register width.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                plfc_pkg::REG_DETECT_ECHO_MAX:
                    regs_next.detect_echo_max_us = cfg.data[plfc_pkg::EchoW-1:0];
                plfc_pkg::REG_REQUIRED_DETECTS:
                    regs_next.required_detects = cfg.data[plfc_pkg::CountW-1:0];
                plfc_pkg::REG_HOLD_MS:
                    regs_next.hold_ms = cfg.data[plfc_pkg::MsW-1:0];
                plfc_pkg::REG_FULL_ECHO_MAX:
                    regs_next.full_echo_max_us = cfg.data[plfc_pkg::EchoW-1:0];
                plfc_pkg::REG_MEDIUM_ECHO_MAX:
                    regs_next.medium_echo_max_us = cfg.data[plfc_pkg::EchoW-1:0];
                plfc_pkg::REG_BUZZ_MS:
                    regs_next.buzz_ms = cfg.data[plfc_pkg::MsW-1:0];
                plfc_pkg::REG_ANGLE_OPEN:
                    regs_next.angle_open = cfg.data[plfc_pkg::AngleW-1:0];
                plfc_pkg::REG_CLOSED_ANGLE:
                    regs_next.closed_angle = cfg.data[plfc_pkg::AngleW-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.detect_echo_max_us <= plfc_pkg::RST_DETECT_ECHO_MAX;
            regs_reg.required_detects   <= plfc_pkg::RST_REQUIRED_DETECTS;
            regs_reg.hold_ms            <= plfc_pkg::RST_HOLD_MS;
            regs_reg.full_echo_max_us   <= plfc_pkg::RST_FULL_ECHO_MAX;
            regs_reg.medium_echo_max_us <= plfc_pkg::RST_MEDIUM_ECHO_MAX;
            regs_reg.buzz_ms            <= plfc_pkg::RST_BUZZ_MS;
            regs_reg.angle_open         <= plfc_pkg::RST_ANGLE_OPEN;
            regs_reg.closed_angle       <= plfc_pkg::RST_CLOSED_ANGLE;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

>>> src/plfc_lid_ctrl.sv
module plfc_lid_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  plfc_pkg::cfg_t              regs,
    input  logic                        step,
    input  logic [plfc_pkg::TimeW-1:0]  now_ms,
    input  logic [plfc_pkg::EchoW-1:0]  outer_echo_us,
    output logic                        lid_open
);

    logic                        lid_is_open_reg;
    logic                        lid_is_open_next;
    logic [plfc_pkg::CountW-1:0] hand_count_reg;
    logic [plfc_pkg::CountW-1:0] hand_count_next;
    logic [plfc_pkg::TimeW-1:0]  last_seen_ms_reg;
    logic [plfc_pkg::TimeW-1:0]  last_seen_ms_next;

    logic                        hand;
    logic [plfc_pkg::CountW-1:0] count_upd;
    logic                        opening;
    logic                        open_mid;
    logic [plfc_pkg::TimeW-1:0]  elapsed;

    // Hand detection and saturating consecutive-hand counter.
    assign hand = (outer_echo_us != '0) && (outer_echo_us <= regs.detect_echo_max_us);

    always_comb
    begin
        if (!hand)
        begin
            count_upd = '0;
        end
        else if (hand_count_reg < regs.required_detects)
        begin
            count_upd = hand_count_reg + 1'b1;
        end
        else
        begin
            count_upd = hand_count_reg;
        end
    end

    // Opening, hold restart on a hand, and close after the hold time.
    assign opening  = !lid_is_open_reg && (count_upd >= regs.required_detects);
    assign open_mid = lid_is_open_reg || opening;

    always_comb
    begin
        last_seen_ms_next = last_seen_ms_reg;
        if (opening || (open_mid && hand))
        begin
            last_seen_ms_next = now_ms;
        end
    end

    // Elapsed time wraps modulo the timestamp width.
    assign elapsed = now_ms - last_seen_ms_next;

    always_comb
    begin
        lid_is_open_next = open_mid;
        hand_count_next  = opening ? '0 : count_upd;
        if (open_mid && (elapsed >= {{(plfc_pkg::TimeW-plfc_pkg::MsW){1'b0}}, regs.hold_ms}))
        begin
            lid_is_open_next = 1'b0;
            hand_count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lid_is_open_reg  <= 1'b0;
            hand_count_reg   <= '0;
            last_seen_ms_reg <= '0;
        end
        else if (step)
        begin
            lid_is_open_reg  <= lid_is_open_next;
            hand_count_reg   <= hand_count_next;
            last_seen_ms_reg <= last_seen_ms_next;
        end
    end

    assign lid_open = lid_is_open_next;

endmodule

>>> src/plfc_fill_ctrl.sv
module plfc_fill_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  plfc_pkg::cfg_t              regs,
    input  logic                        step,
    input  logic [plfc_pkg::TimeW-1:0]  now_ms,
    input  logic [plfc_pkg::EchoW-1:0]  inner_echo_us,
    output logic [plfc_pkg::LevelW-1:0] fill_level,
    output logic                        buzzer_on
);

    logic                       buzz_active_reg;
    logic                       buzz_active_next;
    logic [plfc_pkg::TimeW-1:0] buzz_start_ms_reg;
    logic [plfc_pkg::TimeW-1:0] buzz_start_ms_next;

    logic [plfc_pkg::LevelW-1:0] level;
    logic                        start;
    logic                        active_mid;
    logic [plfc_pkg::TimeW-1:0]  elapsed;

    // Classify the inner echo; full wins over medium.
    always_comb
    begin
        if (inner_echo_us == '0)
        begin
            level = plfc_pkg::LEVEL_EMPTY;
        end
        else if (inner_echo_us <= regs.full_echo_max_us)
        begin
            level = plfc_pkg::LEVEL_FULL;
        end
        else if (inner_echo_us <= regs.medium_echo_max_us)
        begin
            level = plfc_pkg::LEVEL_MEDIUM;
        end
        else
        begin
            level = plfc_pkg::LEVEL_EMPTY;
        end
    end

    // A full bin starts a burst when the buzzer is idle.
    assign start              = (level == plfc_pkg::LEVEL_FULL) && !buzz_active_reg;
    assign active_mid         = buzz_active_reg || start;
    assign buzz_start_ms_next = start ? now_ms : buzz_start_ms_reg;
    assign elapsed            = now_ms - buzz_start_ms_next;

    // The burst ends once its length has elapsed.
    assign buzz_active_next = active_mid &&
        (elapsed < {{(plfc_pkg::TimeW-plfc_pkg::MsW){1'b0}}, regs.buzz_ms});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buzz_active_reg   <= 1'b0;
            buzz_start_ms_reg <= '0;
        end
        else if (step)
        begin
            buzz_active_reg   <= buzz_active_next;
            buzz_start_ms_reg <= buzz_start_ms_next;
        end
    end

    assign fill_level = level;
    assign buzzer_on  = buzz_active_next;

endmodule

>>> src/proximity_lid_and_fill_controller_unit.sv
// Channel   Direction  Handshake      Carries
// sample    in         valid/ready    now_ms, outer_echo_us, inner_echo_us
// result    out        valid/ready    lid_open, servo_angle, fill_level, buzzer_on
// cfg       in         valid/ready    index, data (register write, always ready)
//
// One item per cycle sustained while the result side is ready; an accepted sample is held in
// the input register, then the lid and fill update loads its result into the result register,
// which then presents it as valid.
// The controller state advances in the same cycle the result register is loaded.
// rst_n is asynchronous, active low; it restores register defaults and clears the valid flags and controller state.
// A stalled result holds the result register, and the input register still takes one item.
module proximity_lid_and_fill_controller_unit
(
    input  logic        clk,
    input  logic        rst_n,
    plfc_in_if.sink     sample,
    plfc_out_if.source  result,
    plfc_cfg_if.sink    cfg
);

    plfc_pkg::cfg_t regs;

    logic              in_valid_reg;
    logic              in_valid_next;
    plfc_pkg::sample_t in_data_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        lid_open_reg;
    logic [plfc_pkg::AngleW-1:0] servo_angle_reg;
    logic [plfc_pkg::LevelW-1:0] fill_level_reg;
    logic                        buzzer_on_reg;

    logic                        step;
    logic                        lid_open;
    logic [plfc_pkg::LevelW-1:0] fill_level;
    logic                        buzzer_on;

    plfc_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Pipeline control: the held item moves on when the result slot frees.
    assign step         = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample.valid && sample.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_data_reg.now_ms        <= sample.now_ms;
            in_data_reg.outer_echo_us <= sample.outer_echo_us;
            in_data_reg.inner_echo_us <= sample.inner_echo_us;
        end
    end

    plfc_lid_ctrl u_lid_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .regs          (regs),
        .step          (step),
        .now_ms        (in_data_reg.now_ms),
        .outer_echo_us (in_data_reg.outer_echo_us),
        .lid_open      (lid_open)
    );

    plfc_fill_ctrl u_fill_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .regs          (regs),
        .step          (step),
        .now_ms        (in_data_reg.now_ms),
        .inner_echo_us (in_data_reg.inner_echo_us),
        .fill_level    (fill_level),
        .buzzer_on     (buzzer_on)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            lid_open_reg    <= lid_open;
            servo_angle_reg <= lid_open ? regs.angle_open : regs.closed_angle;
            fill_level_reg  <= fill_level;
            buzzer_on_reg   <= buzzer_on;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.lid_open    = lid_open_reg;
    assign result.servo_angle = servo_angle_reg;
    assign result.fill_level  = fill_level_reg;
    assign result.buzzer_on   = buzzer_on_reg;

    // An accepted sample is held in the input register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> in_valid_reg)
        else $error("accepted sample missing from input register");

    // The fill level never carries the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.fill_level <= plfc_pkg::LEVEL_FULL))
        else $error("fill level out of range");

    // An open lid shows the configured open angle on the servo.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.lid_open) |-> (result.servo_angle == regs.angle_open))
        else $error("servo angle does not match open lid");

    // A held item moves on whenever the result slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held item did not advance into free result slot");

endmodule

>>> tb/sv/proximity_lid_and_fill_controller_unit_test.sv
`timescale 1ns / 100ps

module proximity_lid_and_fill_controller_unit_test;
    import plfc_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int MaxEcho    = 30000;

    // One result item as the block presents it
    typedef struct packed {
        logic              lid_open;
        logic [AngleW-1:0] servo_angle;
        logic [LevelW-1:0] fill_level;
        logic              buzzer_on;
    } lid_fill_t;

    logic clk = 1'b0;
    logic rst_n;

    plfc_in_if  sample_ch();
    plfc_out_if result_ch();
    plfc_cfg_if cfg_ch();

    proximity_lid_and_fill_controller_unit u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predicted register contents and controller state.
    cfg_t               cfg_now;
    logic               lid_up;
    logic [CountW-1:0]  hand_run;
    logic [TimeW-1:0]   seen_ms;
    logic               buzzing;
    logic [TimeW-1:0]   buzz_t0;

    sample_t   pending_samples[$];
    lid_fill_t expected_outputs[$];

    int items_queued = 0;
    int items_sent = 0;
    int results_seen = 0;
    int failures = 0;
    int mismatches = 0;
    int lid_openings = 0;
    int buzz_bursts = 0;
    int settings_run = 1;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;

    // Stimulus generator state.
    logic [TimeW-1:0] clock_ms;
    int hand_left = 0;
    int miss_left = 0;
    int full_left = 0;

    // Advance the predicted controller by one sample and return its outputs.
    function automatic lid_fill_t step_controller(sample_t s);
        lid_fill_t         r;
        logic              hand;
        logic [LevelW-1:0] level;
        logic [TimeW-1:0]  elapsed;
        hand = (s.outer_echo_us != '0) && (s.outer_echo_us <= cfg_now.detect_echo_max_us);

        // Consecutive hand samples saturate at the limit; a miss clears them.
        if (hand)
        begin
            if (hand_run < cfg_now.required_detects)
                hand_run = hand_run + 1'b1;
        end
        else
            hand_run = '0;

        // Open on reaching the limit, then hold while hands keep appearing.
        if (!lid_up && hand_run >= cfg_now.required_detects)
        begin
            lid_up = 1'b1;
            seen_ms = s.now_ms;
            hand_run = '0;
            lid_openings++;
        end
        if (lid_up)
        begin
            if (hand)
                seen_ms = s.now_ms;
            elapsed = s.now_ms - seen_ms;
            if (elapsed >= cfg_now.hold_ms)
            begin
                lid_up = 1'b0;
                hand_run = '0;
            end
        end

        // Fill level; full is tested ahead of medium.
        if (s.inner_echo_us == '0)
            level = LEVEL_EMPTY;
        else if (s.inner_echo_us <= cfg_now.full_echo_max_us)
            level = LEVEL_FULL;
        else if (s.inner_echo_us <= cfg_now.medium_echo_max_us)
            level = LEVEL_MEDIUM;
        else
            level = LEVEL_EMPTY;

        // A full bin starts a burst if none runs; the burst ends after buzz_ms.
        if (level == LEVEL_FULL && !buzzing)
        begin
            buzzing = 1'b1;
            buzz_t0 = s.now_ms;
            buzz_bursts++;
        end
        elapsed = s.now_ms - buzz_t0;
        if (buzzing && elapsed >= cfg_now.buzz_ms)
            buzzing = 1'b0;

        r.lid_open = lid_up;
        r.servo_angle = lid_up ? cfg_now.angle_open : cfg_now.closed_angle;
        r.fill_level = level;
        r.buzzer_on = buzzing;
        return r;
    endfunction

    // Idle length for either side: mostly short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 3);
        if (roll < 90)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // Sample driver: takes items from the pending queue.
    always @(posedge clk)
    begin : drive_samples
        sample_t nxt;
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                nxt.now_ms = sample_ch.now_ms;
                nxt.outer_echo_us = sample_ch.outer_echo_us;
                nxt.inner_echo_us = sample_ch.inner_echo_us;
                expected_outputs.push_back(step_controller(nxt));
                items_sent++;
                // Every fourth block of a hundred items runs without gaps.
                if ((items_sent / 100) % 4 == 1 || $urandom_range(0, 1) == 0)
                    send_gap = 0;
                else
                    send_gap = pick_gap();
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    nxt = pending_samples.pop_front();
                    sample_ch.valid <= 1'b1;
                    sample_ch.now_ms <= nxt.now_ms;
                    sample_ch.outer_echo_us <= nxt.outer_echo_us;
                    sample_ch.inner_echo_us <= nxt.inner_echo_us;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each item with the oldest prediction.
    always @(posedge clk)
    begin : watch_results
        lid_fill_t want;
        logic      bad;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_outputs.size() == 0)
                begin
                    failures++;
                    $display("Result item %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    bad = 1'b0;
                    if (result_ch.lid_open !== want.lid_open)
                        bad = 1'b1;
                    if (result_ch.servo_angle !== want.servo_angle)
                        bad = 1'b1;
                    if (result_ch.fill_level !== want.fill_level)
                        bad = 1'b1;
                    if (result_ch.buzzer_on !== want.buzzer_on)
                        bad = 1'b1;
                    if (bad)
                    begin
                        failures++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch on result %0d: expected lid %0d angle %0d ",
                                      "level %0d buzzer %0d, got lid %0d angle %0d level %0d ",
                                      "buzzer %0d"},
                                     results_seen, want.lid_open, want.servo_angle,
                                     want.fill_level, want.buzzer_on, result_ch.lid_open,
                                     result_ch.servo_angle, result_ch.fill_level,
                                     result_ch.buzzer_on);
                    end
                end
            end

            // Receiver stalls, with quiet stretches where no new stall begins.
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ((cycle_count / 400) % 4 != 2 && $urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
            end
        end
    end

    // Run length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Run exceeded %0d cycles with %0d of %0d results seen",
                     CycleLimit, results_seen, items_queued);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_sample(input logic [TimeW-1:0] now, input int outer, input int inner);
        sample_t s;
        s.now_ms = now;
        s.outer_echo_us = outer[EchoW-1:0];
        s.inner_echo_us = inner[EchoW-1:0];
        pending_samples.push_back(s);
        items_queued++;
    endtask

    // Waits until every queued sample has produced its result.
    task automatic wait_drained();
        while (results_seen < items_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDatW-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_DETECT_ECHO_MAX:  cfg_now.detect_echo_max_us = value[EchoW-1:0];
            REG_REQUIRED_DETECTS: cfg_now.required_detects = value[CountW-1:0];
            REG_HOLD_MS:          cfg_now.hold_ms = value[MsW-1:0];
            REG_FULL_ECHO_MAX:    cfg_now.full_echo_max_us = value[EchoW-1:0];
            REG_MEDIUM_ECHO_MAX:  cfg_now.medium_echo_max_us = value[EchoW-1:0];
            REG_BUZZ_MS:          cfg_now.buzz_ms = value[MsW-1:0];
            REG_ANGLE_OPEN:       cfg_now.angle_open = value[AngleW-1:0];
            REG_CLOSED_ANGLE:     cfg_now.closed_angle = value[AngleW-1:0];
            default:              ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    // Loads a full register setting; only called with the block drained.
    task automatic apply_setting(input logic [CfgDatW-1:0] detect, input logic [CfgDatW-1:0] need,
                                 input logic [CfgDatW-1:0] hold, input logic [CfgDatW-1:0] full,
                                 input logic [CfgDatW-1:0] mid_max, input logic [CfgDatW-1:0] buzz,
                                 input logic [CfgDatW-1:0] open_deg,
                                 input logic [CfgDatW-1:0] closed_deg);
        wait_drained();
        write_register(REG_DETECT_ECHO_MAX, detect);
        write_register(REG_REQUIRED_DETECTS, need);
        write_register(REG_HOLD_MS, hold);
        write_register(REG_FULL_ECHO_MAX, full);
        write_register(REG_MEDIUM_ECHO_MAX, mid_max);
        write_register(REG_BUZZ_MS, buzz);
        write_register(REG_ANGLE_OPEN, open_deg);
        write_register(REG_CLOSED_ANGLE, closed_deg);
        settings_run++;
    endtask

    // Outer echo: runs of hand readings separated by runs of misses.
    function automatic int next_outer();
        int detect;
        int roll;
        detect = cfg_now.detect_echo_max_us;
        if (hand_left == 0 && miss_left == 0)
        begin
            if ($urandom_range(0, 99) < 65)
                hand_left = $urandom_range(1, cfg_now.required_detects + 4);
            else
                miss_left = $urandom_range(1, 5);
        end
        roll = $urandom_range(0, 99);
        if (hand_left > 0 && detect > 0)
        begin
            hand_left--;
            if (detect > MaxEcho)
                detect = MaxEcho;
            if (roll < 20)
                return detect;
            if (roll < 30)
                return 1;
            return $urandom_range(1, detect);
        end
        hand_left = 0;
        if (miss_left > 0)
            miss_left--;
        if (roll < 40)
            return 0;
        if (roll < 60 && detect < MaxEcho)
            return detect + 1;
        return $urandom_range(0, MaxEcho);
    endfunction

    // Inner echo: stretches of a full bin, plus values around both thresholds.
    function automatic int next_inner();
        int full;
        int mid_max;
        int roll;
        full = cfg_now.full_echo_max_us;
        mid_max = cfg_now.medium_echo_max_us;
        if (full > MaxEcho)
            full = MaxEcho;
        if (mid_max > MaxEcho)
            mid_max = MaxEcho;
        if (full_left > 0 && full > 0)
        begin
            full_left--;
            return $urandom_range(1, full);
        end
        roll = $urandom_range(0, 99);
        if (roll < 10)
            full_left = $urandom_range(1, 8);
        if (roll < 25)
            return 0;
        if (roll < 35)
            return (full < MaxEcho) ? full + 1 : full;
        if (roll < 45)
            return mid_max;
        if (roll < 55)
            return (mid_max < MaxEcho) ? mid_max + 1 : mid_max;
        return $urandom_range(0, MaxEcho);
    endfunction

    task automatic queue_random_samples(input int count);
        int roll;
        int outer;
        int inner;
        for (int i = 0; i < count; i++)
        begin
            // Mostly the 60 ms sample pace, with repeats, long jumps and wild jumps.
            roll = $urandom_range(0, 99);
            if (roll < 70)
                clock_ms = clock_ms + $urandom_range(40, 80);
            else if (roll < 80)
                clock_ms = clock_ms + $urandom_range(0, 5);
            else if (roll < 95)
                clock_ms = clock_ms + $urandom_range(0, 70000);
            else
                clock_ms = clock_ms + $urandom();
            if ($urandom_range(0, 99) < 8)
            begin
                outer = $urandom_range(0, MaxEcho);
                inner = $urandom_range(0, MaxEcho);
            end
            else
            begin
                outer = next_outer();
                inner = next_inner();
            end
            queue_sample(clock_ms, outer, inner);
        end
    endtask

    initial
    begin : run_test
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.now_ms = '0;
        sample_ch.outer_echo_us = '0;
        sample_ch.inner_echo_us = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;

        cfg_now.detect_echo_max_us = RST_DETECT_ECHO_MAX;
        cfg_now.required_detects = RST_REQUIRED_DETECTS;
        cfg_now.hold_ms = RST_HOLD_MS;
        cfg_now.full_echo_max_us = RST_FULL_ECHO_MAX;
        cfg_now.medium_echo_max_us = RST_MEDIUM_ECHO_MAX;
        cfg_now.buzz_ms = RST_BUZZ_MS;
        cfg_now.angle_open = RST_ANGLE_OPEN;
        cfg_now.closed_angle = RST_CLOSED_ANGLE;
        lid_up = 1'b0;
        hand_run = '0;
        seen_ms = '0;
        buzzing = 1'b0;
        buzz_t0 = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples with the reset settings: threshold edges, opening on
        // the second hand, hold expiry, buzzer expiry and retrigger, timestamp wrap.
        queue_sample(32'd0, 0, 0);
        queue_sample(32'd60, 583, 30000);
        queue_sample(32'd120, 1, 700);
        queue_sample(32'd180, 584, 699);
        queue_sample(32'd3120, 0, 292);
        queue_sample(32'd3180, 30000, 291);
        queue_sample(32'd4179, 0, 1);
        queue_sample(32'd4180, 0, 1);
        queue_sample(32'd4240, 0, 1);
        queue_sample(32'hFFFF_FFC0, 100, 0);
        queue_sample(32'hFFFF_FFFF, 100, 16383);
        queue_sample(32'h0000_0BB6, 0, 0);
        queue_sample(32'h0000_0BB7, 0, 0);
        queue_sample(32'd5000, 50, 0);
        queue_sample(32'd5060, 50, 0);
        queue_sample(32'd7000, 50, 0);
        queue_sample(32'd7000, 0, 0);
        queue_sample(32'd9999, 0, 0);
        queue_sample(32'd10000, 0, 0);
        clock_ms = 32'd10000;
        queue_random_samples(130);

        // Low extremes of every register but the closed angle, which takes 180.
        apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd180);
        clock_ms = $urandom();
        queue_random_samples(135);

        // High extremes of every register but the closed angle, which takes 0.
        apply_setting(16'd30000, 16'd15, 16'd65535, 16'd30000, 16'd30000, 16'd65535,
                      16'd180, 16'd0);
        clock_ms = 32'hFFFF_FF00;
        queue_random_samples(135);

        // Zero detects, zero hold and zero burst length; angles above 180.
        apply_setting(16'd583, 16'd0, 16'd0, 16'd291, 16'd699, 16'd0, 16'd255, 16'd200);
        clock_ms = $urandom();
        queue_random_samples(135);

        // Full threshold above the medium one.
        apply_setting(16'd2000, 16'd3, 16'd500, 16'd800, 16'd300, 16'd200, 16'd90, 16'd45);
        clock_ms = $urandom();
        queue_random_samples(135);

        // Data bits above each register width are dropped.
        apply_setting(16'h83E8, 16'hFFF5, 16'h07D0, 16'hC190, 16'hC320, 16'h0258,
                      16'hAB7F, 16'h5A14);
        clock_ms = $urandom();
        queue_random_samples(135);

        // Random in-range settings.
        for (int k = 0; k < 3; k++)
        begin
            apply_setting(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 6)),
                          16'($urandom_range(1, 5000)), 16'($urandom_range(1, 1500)),
                          16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                          16'($urandom_range(0, 180)), 16'($urandom_range(0, 180)));
            clock_ms = $urandom();
            queue_random_samples(135);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_outputs.size() != 0)
        begin
            failures += expected_outputs.size();
            $display("%0d predicted results never arrived", expected_outputs.size());
        end

        $display("Sent %0d samples over %0d register settings; %0d results compared.",
                 items_sent, settings_run, results_seen);
        $display("The lid opened %0d times and the buzzer fired %0d bursts; %0d failures.",
                 lid_openings, buzz_bursts, failures);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
